// File: design/tpi_pkg.sv
// Shared types and constants for the tolerant palette indexer.
`default_nettype none

package tpi_pkg;

    localparam int CHAN_W  = 8;
    localparam int TOL_W   = 9;
    localparam int CODE_W  = 8;
    localparam int COUNT_W = 9;

    localparam logic [TOL_W-1:0] TOL_RESET = 9'd26;
    localparam logic [TOL_W-1:0] TOL_ONE   = 9'd256;
    localparam logic [CHAN_W-1:0] CHAN_MAX = 8'd255;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } t_rgb;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic              start_req;
    } t_pix_in;

    typedef struct packed {
        logic [CODE_W-1:0]  code;
        logic               added;
        logic               overflow;
        logic [COUNT_W-1:0] entry_count;
    } t_pix_out;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_FINISH
    } t_state;

endpackage

`default_nettype wire

// File: design/tpi_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module tpi_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output      logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// File: design/tpi_match.sv
// Tolerance window compare of one pixel against one palette entry.
`default_nettype none

module tpi_match
    import tpi_pkg::*;
(
    input  wire t_rgb             i_pixel,
    input  wire t_rgb             i_entry,
    input  wire logic [TOL_W-1:0] i_tol,
    output      logic             o_match
);

    logic [CHAN_W-1:0] pix_ch [3];
    logic [CHAN_W-1:0] ent_ch [3];
    logic [2:0]        ch_fit;
    logic              tol_sat;
    logic [TOL_W-1:0]  lo_scale;
    logic [TOL_W:0]    hi_scale;

    assign pix_ch[0] = i_pixel.red;
    assign pix_ch[1] = i_pixel.green;
    assign pix_ch[2] = i_pixel.blue;
    assign ent_ch[0] = i_entry.red;
    assign ent_ch[1] = i_entry.green;
    assign ent_ch[2] = i_entry.blue;

    assign tol_sat  = (i_tol >= TOL_ONE);
    assign lo_scale = TOL_ONE - i_tol;
    assign hi_scale = {1'b0, TOL_ONE} + {1'b0, i_tol};

    for (genvar k = 0; k < 3; k++) begin : g_chan
        logic [CHAN_W+TOL_W-1:0]  lo_prod;
        logic [CHAN_W+TOL_W:0]    hi_prod;
        logic [CHAN_W:0]          lo_bound;
        logic [CHAN_W+1:0]        hi_raw;
        logic [CHAN_W+1:0]        hi_bound;

        assign lo_prod  = {{TOL_W{1'b0}}, ent_ch[k]} * {{CHAN_W{1'b0}}, lo_scale};
        assign hi_prod  = {{(TOL_W+1){1'b0}}, ent_ch[k]} * {{CHAN_W{1'b0}}, hi_scale};
        // Floor by dropping the eight fraction bits; saturate both ends.
        assign lo_bound = tol_sat ? '0 : lo_prod[CHAN_W+TOL_W-1:8];
        assign hi_raw   = hi_prod[CHAN_W+TOL_W:8];
        assign hi_bound = (hi_raw > {2'b00, CHAN_MAX}) ? {2'b00, CHAN_MAX} : hi_raw;
        assign ch_fit[k] = ({1'b0, pix_ch[k]} >= lo_bound)
                        && ({2'b00, pix_ch[k]} <= hi_bound);
    end

    assign o_match = &ch_fit;

endmodule

`default_nettype wire

// File: design/tolerant_palette_indexer.sv
// Tolerant palette indexer: first-fit palette search with one compare per cycle.
// An item that matches entry n ends its search there; an appended or overflowing item is compared
// against every entry below the fill (none at zero tolerance). A new item is taken once the prior result
// leaves ST_FINISH; the single window compare unit steps one palette RAM entry per cycle.
// Reset: empties the palette fill count, sets tolerance to 26/256, clears the output valid flag.
// Palette RAM contents are not cleared; only entries below the fill count are ever used in a compare.
`default_nettype none

module tolerant_palette_indexer
    import tpi_pkg::*;
#(
    parameter int PALETTE_DEPTH = 256
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output      logic             o_in_ready,
    input  wire t_pix_in          i_in_data,
    output      logic             o_out_valid,
    input  wire logic             i_out_ready,
    output      t_pix_out         o_out_data,
    input  wire logic             i_cfg_valid,
    output      logic             o_cfg_ready,
    input  wire logic [TOL_W-1:0] i_cfg_data
);

    localparam int AW = $clog2(PALETTE_DEPTH);
    localparam int CW = $clog2(PALETTE_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(PALETTE_DEPTH);
    localparam logic [CW-1:0] ONE_C   = CW'(1);

    t_state           r_state, n_state;
    logic [TOL_W-1:0] r_tol;
    logic [CW-1:0]    r_fill, n_fill;
    logic [CW-1:0]    r_idx, n_idx;
    t_rgb             r_pix, n_pix;
    t_pix_out         r_res, n_res;
    t_pix_out         r_out, n_out;
    logic             r_out_valid, n_out_valid;

    logic             in_xfer;
    logic             out_xfer;
    logic             ram_we;
    logic [AW-1:0]    ram_raddr;
    logic [CW-1:0]    idx_inc;
    logic [CW-1:0]    fill_inc;
    t_rgb             entry;
    logic             hit;
    logic [CW+CODE_W-1:0]  idx_ext;
    logic [CW+CODE_W-1:0]  fill_ext;
    logic [CW+COUNT_W-1:0] cnt_ext;
    logic [CW+COUNT_W-1:0] cnt_inc_ext;

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign in_xfer  = i_in_valid && o_in_ready;
    assign out_xfer = r_out_valid && i_out_ready;

    assign idx_inc     = r_idx + ONE_C;
    assign fill_inc    = r_fill + ONE_C;
    assign idx_ext     = {{CODE_W{1'b0}}, r_idx};
    assign fill_ext    = {{CODE_W{1'b0}}, r_fill};
    assign cnt_ext     = {{COUNT_W{1'b0}}, r_fill};
    assign cnt_inc_ext = {{COUNT_W{1'b0}}, fill_inc};

    // Prefetch entry 0 while idle, then the entry after the one under compare.
    assign ram_raddr = (r_state == ST_IDLE) ? '0 : idx_inc[AW-1:0];

    tpi_ram #(
        .WIDTH ($bits(t_rgb)),
        .DEPTH (PALETTE_DEPTH)
    ) u_palette (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_fill[AW-1:0]),
        .i_wdata (r_pix),
        .i_raddr (ram_raddr),
        .o_rdata (entry)
    );

    tpi_match u_match (
        .i_pixel (r_pix),
        .i_entry (entry),
        .i_tol   (r_tol),
        .o_match (hit)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_tol       <= TOL_RESET;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_tol <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        r_pix <= n_pix;
        r_res <= n_res;
        r_out <= n_out;
    end

    always_comb begin
        n_state     = r_state;
        n_fill      = r_fill;
        n_idx       = r_idx;
        n_pix       = r_pix;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid && !out_xfer;
        ram_we      = 1'b0;

        case (r_state)
            ST_IDLE: begin
                if (in_xfer) begin
                    n_pix.red   = i_in_data.red;
                    n_pix.green = i_in_data.green;
                    n_pix.blue  = i_in_data.blue;
                    if (i_in_data.start_req) begin
                        n_fill = '0;
                    end
                    // Zero tolerance: start past the last entry so nothing is compared.
                    n_idx   = (r_tol == '0) ? n_fill : '0;
                    n_state = ST_SEARCH;
                end
            end
            ST_SEARCH: begin
                if (r_idx >= r_fill) begin
                    if (r_fill < DEPTH_C) begin
                        ram_we            = 1'b1;
                        n_fill            = fill_inc;
                        n_res.code        = fill_ext[CODE_W-1:0];
                        n_res.added       = 1'b1;
                        n_res.overflow    = 1'b0;
                        n_res.entry_count = cnt_inc_ext[COUNT_W-1:0];
                    end else begin
                        n_res.code        = '0;
                        n_res.added       = 1'b0;
                        n_res.overflow    = 1'b1;
                        n_res.entry_count = cnt_ext[COUNT_W-1:0];
                    end
                    n_state = ST_FINISH;
                end else if (hit) begin
                    n_res.code        = idx_ext[CODE_W-1:0];
                    n_res.added       = 1'b0;
                    n_res.overflow    = 1'b0;
                    n_res.entry_count = cnt_ext[COUNT_W-1:0];
                    n_state           = ST_FINISH;
                end else begin
                    n_idx = idx_inc;
                end
            end
            ST_FINISH: begin
                // Hold the result until the output register is free.
                if (!r_out_valid || i_out_ready) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire
